@@ src/qpwc_pkg.sv @@
// shared types and constants for the queued pulse width command transmitter
package qpwc_pkg;

  localparam int CODE_W   = 8;
  localparam int DUR_W    = 16;
  localparam int MODE_W   = 2;
  localparam int STEP_W   = 5;
  localparam int CFG_IDX_W = 3;

  // item modes
  localparam logic [MODE_W-1:0] MODE_ENQUEUE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DIRECT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_POLL    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PULSE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PULSE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED    = 3'd4;

  // register reset values
  localparam logic [DUR_W-1:0]  START_LOW_RST   = 16'd5000;
  localparam logic [DUR_W-1:0]  LONG_PULSE_RST  = 16'd600;
  localparam logic [DUR_W-1:0]  SHORT_PULSE_RST = 16'd200;
  localparam logic [DUR_W-1:0]  STOP_HIGH_RST   = 16'd100;
  localparam logic [CODE_W-1:0] RESERVED_RST    = 8'd0;

  // frame sequencing
  localparam logic [DUR_W-1:0]  LEAD_IN_US = 16'd2;
  localparam logic [STEP_W-1:0] STEP_START = 5'd0;
  localparam logic [STEP_W-1:0] STEP_STOP  = 5'd17;
  localparam logic [STEP_W-1:0] STEP_COUNT = 5'd18;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CODE_W-1:0] code;
    logic              chip_busy;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic sending;
    logic queue_empty;
    logic frame_done;
  } out_item_t;

  typedef struct packed {
    logic [DUR_W-1:0] start_low;
    logic [DUR_W-1:0] long_pulse;
    logic [DUR_W-1:0] short_pulse;
    logic [DUR_W-1:0] stop_high;
  } timing_cfg_t;

  typedef struct packed {
    logic              start;
    logic              tick;
    logic [CODE_W-1:0] code;
  } frame_ctl_t;

  typedef struct packed {
    logic line_level;
    logic sending;
    logic frame_done;
  } frame_stat_t;

endpackage

@@ src/qpwc_ring.sv @@
// ring of command codes with a prefetched head entry
module qpwc_ring #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push_en,
  input  logic [qpwc_pkg::CODE_W-1:0] push_code,
  input  logic                        pop_en,
  output logic [qpwc_pkg::CODE_W-1:0] head_code,
  output logic                        empty,
  output logic                        empty_nxt
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [qpwc_pkg::CODE_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]            wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [qpwc_pkg::CODE_W-1:0] rd_data_r;
  logic [qpwc_pkg::CODE_W-1:0] byp_data_r;
  logic                        byp_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign wr_ptr_nxt = push_en ? ptr_inc(wr_ptr_r) : wr_ptr_r;
  assign rd_ptr_nxt = pop_en  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
  assign empty      = (rd_ptr_r == wr_ptr_r);
  assign empty_nxt  = (rd_ptr_nxt == wr_ptr_nxt);

  // head comes from the memory, or from a write that hit the head address
  assign head_code = byp_r ? byp_data_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      byp_r    <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      byp_r    <= push_en && (wr_ptr_r == rd_ptr_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[wr_ptr_r] <= push_code;
    end
    rd_data_r  <= mem[rd_ptr_nxt];
    byp_data_r <= push_code;
  end

endmodule

@@ src/qpwc_frame.sv @@
// frame sequencer: lead-in, start pulse, eight bit cells and stop pulse
module qpwc_frame #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  qpwc_pkg::frame_ctl_t   ctl,
  input  qpwc_pkg::timing_cfg_t  timing,
  output qpwc_pkg::frame_stat_t  stat_nxt
);

  localparam int EXT_W = (COUNT_WIDTH > qpwc_pkg::DUR_W) ? COUNT_WIDTH : qpwc_pkg::DUR_W;
  localparam logic [EXT_W-1:0] CNT_MAX_EXT = EXT_W'({COUNT_WIDTH{1'b1}});

  logic [qpwc_pkg::CODE_W-1:0] code_r, code_nxt;
  logic [qpwc_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [COUNT_WIDTH-1:0]      count_r, count_nxt;
  logic                        active_r, active_nxt;
  logic                        line_r, line_nxt;
  logic                        done;
  logic [qpwc_pkg::STEP_W-1:0] phase_idx;
  logic                        cell_bit;
  logic                        step_lvl;
  logic [qpwc_pkg::DUR_W-1:0]  step_dur;

  function automatic logic [COUNT_WIDTH-1:0] clamp_count(input logic [qpwc_pkg::DUR_W-1:0] us);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(us);
    clamp_count = (ext > CNT_MAX_EXT) ? {COUNT_WIDTH{1'b1}} : ext[COUNT_WIDTH-1:0];
  endfunction

  // level and duration of the step about to run
  assign phase_idx = step_r - qpwc_pkg::STEP_W'(1);
  assign cell_bit  = code_r[phase_idx[3:1]];

  always_comb begin
    if (step_r == qpwc_pkg::STEP_START) begin
      step_lvl = 1'b0;
      step_dur = timing.start_low;
    end else if (step_r < qpwc_pkg::STEP_STOP) begin
      step_lvl = !phase_idx[0];
      if (phase_idx[0] == cell_bit) begin
        step_dur = timing.short_pulse;
      end else begin
        step_dur = timing.long_pulse;
      end
    end else begin
      step_lvl = 1'b1;
      step_dur = timing.stop_high;
    end
  end

  always_comb begin
    code_nxt   = code_r;
    step_nxt   = step_r;
    count_nxt  = count_r;
    active_nxt = active_r;
    line_nxt   = line_r;
    done       = 1'b0;
    if (ctl.start) begin
      code_nxt   = ctl.code;
      step_nxt   = qpwc_pkg::STEP_START;
      count_nxt  = clamp_count(qpwc_pkg::LEAD_IN_US);
      active_nxt = 1'b1;
    end else if (ctl.tick && active_r) begin
      if (count_r > COUNT_WIDTH'(1)) begin
        count_nxt = count_r - COUNT_WIDTH'(1);
      end else if (step_r < qpwc_pkg::STEP_COUNT) begin
        line_nxt  = step_lvl;
        count_nxt = clamp_count(step_dur);
        step_nxt  = step_r + qpwc_pkg::STEP_W'(1);
      end else begin
        active_nxt = 1'b0;
        step_nxt   = qpwc_pkg::STEP_START;
        count_nxt  = '0;
        done       = 1'b1;
      end
    end
  end

  assign stat_nxt.line_level = line_nxt;
  assign stat_nxt.sending    = active_nxt;
  assign stat_nxt.frame_done = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r   <= '0;
      step_r   <= '0;
      count_r  <= '0;
      active_r <= 1'b0;
      line_r   <= 1'b1;
    end else begin
      code_r   <= code_nxt;
      step_r   <= step_nxt;
      count_r  <= count_nxt;
      active_r <= active_nxt;
      line_r   <= line_nxt;
    end
  end

endmodule

@@ src/queued_pulse_width_command_tx_core.sv @@
// top level of the queued pulse width command transmitter
//
//   channel  direction  handshake         payload
//   in_      input      valid / stall     in_item_t  (mode, code, chip_busy)
//   out_     output     valid / stall     out_item_t (line_level, sending,
//                                                     queue_empty, frame_done)
//   cfg_     input      valid / ready     3-bit register index, 16-bit data
//
// one item per cycle while out_stall is low; each item is held in the input register and
// its result is registered in the result register when the input register fires
// the rate is set by the single update of counter, step and ring pointers
// synchronous active-low reset; line idles high, ring pointers clear
// a stalled result holds the result register and then the input register;
// cfg_ready is always high

module queued_pulse_width_command_tx_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  qpwc_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output qpwc_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qpwc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qpwc_pkg::DUR_W-1:0]     cfg_data
);

  qpwc_pkg::timing_cfg_t       timing_r;
  logic [qpwc_pkg::CODE_W-1:0] reserved_r;

  logic                  s1_valid_r;
  qpwc_pkg::in_item_t    s1_item_r;
  logic                  out_valid_r;
  qpwc_pkg::out_item_t   out_item_r;
  logic                  out_free;
  logic                  s1_fire;

  logic                        push_en;
  logic                        pop_en;
  logic [qpwc_pkg::CODE_W-1:0] head_code;
  logic                        ring_empty;
  logic                        ring_empty_nxt;
  qpwc_pkg::frame_ctl_t        frame_ctl;
  qpwc_pkg::frame_stat_t       frame_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.start_low   <= qpwc_pkg::START_LOW_RST;
      timing_r.long_pulse  <= qpwc_pkg::LONG_PULSE_RST;
      timing_r.short_pulse <= qpwc_pkg::SHORT_PULSE_RST;
      timing_r.stop_high   <= qpwc_pkg::STOP_HIGH_RST;
      reserved_r           <= qpwc_pkg::RESERVED_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qpwc_pkg::REG_START_LOW:   timing_r.start_low   <= cfg_data;
        qpwc_pkg::REG_LONG_PULSE:  timing_r.long_pulse  <= cfg_data;
        qpwc_pkg::REG_SHORT_PULSE: timing_r.short_pulse <= cfg_data;
        qpwc_pkg::REG_STOP_HIGH:   timing_r.stop_high   <= cfg_data;
        qpwc_pkg::REG_RESERVED:    reserved_r <= cfg_data[qpwc_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // two-register flow: input register, then result register
  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_data;
    end
    if (s1_fire) begin
      out_item_r.line_level  <= frame_stat.line_level;
      out_item_r.sending     <= frame_stat.sending;
      out_item_r.queue_empty <= ring_empty_nxt;
      out_item_r.frame_done  <= frame_stat.frame_done;
    end
  end

  assign push_en = s1_fire && (s1_item_r.mode == qpwc_pkg::MODE_ENQUEUE)
                   && (s1_item_r.code != reserved_r);
  assign pop_en  = s1_fire && (s1_item_r.mode == qpwc_pkg::MODE_POLL)
                   && !s1_item_r.chip_busy && !ring_empty;

  // a popped zero code is dropped
  assign frame_ctl.start = (s1_fire && (s1_item_r.mode == qpwc_pkg::MODE_DIRECT))
                           || (pop_en && (head_code != '0));
  assign frame_ctl.tick  = s1_fire && (s1_item_r.mode == qpwc_pkg::MODE_TICK);
  assign frame_ctl.code  = (s1_item_r.mode == qpwc_pkg::MODE_DIRECT) ? s1_item_r.code
                                                                      : head_code;

  qpwc_ring #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (push_en),
    .push_code (s1_item_r.code),
    .pop_en    (pop_en),
    .head_code (head_code),
    .empty     (ring_empty),
    .empty_nxt (ring_empty_nxt)
  );

  qpwc_frame #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (frame_ctl),
    .timing   (timing_r),
    .stat_nxt (frame_stat)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_done_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |-> !out_data.sending)
    else $error("frame_done reported while still sending");

  a_idle_line_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.sending |-> out_data.line_level)
    else $error("line not high while idle");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_en |-> !ring_empty)
    else $error("pop from empty ring");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    push_en |-> !pop_en && !frame_ctl.tick)
    else $error("push overlaps another ring or frame action");

endmodule
